### design/sstat_pkg.sv
// ----------------------------------------------------------------------------
// sstat_pkg
// Request and response types and fixed constants for sample_set_statistics.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sstat_pkg;

  // Width of the shared divider and of the pass accumulators
  localparam int unsigned DivW    = 64;
  localparam int unsigned DivCntW = $clog2(DivW);

  // Saturation limit of the variance field
  localparam int unsigned VarW = 48;

  // Input request: one sample
  typedef struct packed {
    logic signed [31:0] sample;
    logic               last_sample;
  } in_req_t;

  // Output response: statistics of one set
  typedef struct packed {
    logic        [12:0] count;
    logic signed [31:0] mean;
    logic        [47:0] variance;
    logic signed [43:0] total;
    logic signed [31:0] smallest;
    logic signed [31:0] largest;
    logic        [31:0] avg_deviation;
    logic               overflowed;
  } out_rsp_t;

endpackage

### design/sstat_ram.sv
// ----------------------------------------------------------------------------
// sstat_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sstat_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

### design/sample_set_statistics.sv
// ----------------------------------------------------------------------------
// sample_set_statistics
// Collects a set of signed fixed-point samples, then computes mean, sample
// variance and mean absolute deviation with a second pass over the store.
// ----------------------------------------------------------------------------
// Loading: one sample per cycle, no stall; no sample is taken while a set's statistics are computed.
// Last sample: before the response come a run of the shared 1-bit-per-cycle
//   divider for the mean, the pass that reads one stored sample per cycle, and
//   divider runs for the mean absolute deviation and the variance.
// Reset: set cleared (count, sum, overflow zero; min/max at extremes); the
//   sample store is not cleared and needs no clearing pass.
`timescale 1ns / 1ps

module sample_set_statistics #(
  parameter int unsigned MAX_SAMPLES  = 4096,
  parameter int unsigned SAMPLE_WIDTH = 32,
  parameter int unsigned FRAC_BITS    = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  sstat_pkg::in_req_t in_req_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output sstat_pkg::out_rsp_t out_rsp_o
);

  localparam int unsigned AddrW = $clog2(MAX_SAMPLES);
  localparam int unsigned CntW  = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned SumW  = SAMPLE_WIDTH + CntW;
  localparam int unsigned DivW  = sstat_pkg::DivW;
  localparam int unsigned DcW   = sstat_pkg::DivCntW;

  // Sequencer codes
  localparam logic [2:0] StLoad    = 3'd0;
  localparam logic [2:0] StDivMean = 3'd1;
  localparam logic [2:0] StPass    = 3'd2;
  localparam logic [2:0] StDivAdev = 3'd3;
  localparam logic [2:0] StDivVar  = 3'd4;
  localparam logic [2:0] StFinish  = 3'd5;

  logic [2:0] state_q, state_d;

  // Set state
  logic        [CntW-1:0]         count_q;
  logic signed [SumW-1:0]         sum_q;
  logic signed [SAMPLE_WIDTH-1:0] min_q, max_q;
  logic                           ovf_q;

  // Pass state
  logic signed [SAMPLE_WIDTH-1:0] mean_q;
  logic        [CntW-1:0]         rd_cnt_q;
  logic                           v1_q, v2_q, v3_q;
  logic        [SAMPLE_WIDTH-1:0] abs_q;
  logic        [DivW-1:0]         sq_q;
  logic        [DivW-1:0]         abs_sum_q, sq_sum_q;
  logic        [31:0]             adev_q;

  // Shared divider
  logic [DivW-1:0] quo_q;
  logic [CntW-1:0] rem_q, dvs_q;
  logic [DcW-1:0]  dcnt_q;
  logic [CntW:0]   rem_sh;
  logic            div_ge;
  logic [CntW-1:0] rem_nx;
  logic [DivW-1:0] quo_nx;
  logic            div_last;

  // Output register
  logic                 out_valid_q;
  sstat_pkg::out_rsp_t  out_q;

  // Input side
  logic                           in_fire, room, take;
  logic signed [SAMPLE_WIDTH-1:0] x;
  logic signed [SumW-1:0]         sum_nx;
  logic        [CntW-1:0]         cnt_nx;
  logic signed [SAMPLE_WIDTH:0]   dev;
  logic        [SAMPLE_WIDTH-1:0] dev_abs;
  logic        [2*SAMPLE_WIDTH-1:0] prod;
  logic        [SAMPLE_WIDTH-1:0] rdata;
  logic        [SumW-1:0]         sum_mag;
  logic        [CntW-1:0]         n_dvs, var_dvs;
  logic                           pass_done, fin_go;

  assign in_ready_o = (state_q == StLoad);
  assign in_fire    = in_valid_i && in_ready_o;
  assign x          = $signed(in_req_i.sample[SAMPLE_WIDTH-1:0]);
  assign room       = (count_q < CntW'(MAX_SAMPLES));
  assign take       = in_fire && room;

  // Set count and sum including the sample taken this cycle
  assign sum_nx = take ? sum_q + SumW'(x) : sum_q;
  assign cnt_nx = take ? count_q + CntW'(1) : count_q;

  sstat_ram #(
    .WIDTH(SAMPLE_WIDTH),
    .DEPTH(MAX_SAMPLES)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (take),
    .waddr_i(count_q[AddrW-1:0]),
    .wdata_i(x),
    .raddr_i(rd_cnt_q[AddrW-1:0]),
    .rdata_o(rdata)
  );

  // Divider step: restoring, one quotient bit per cycle
  assign rem_sh   = {rem_q, quo_q[DivW-1]};
  assign div_ge   = (rem_sh >= {1'b0, dvs_q});
  assign rem_nx   = div_ge ? CntW'(rem_sh - {1'b0, dvs_q}) : CntW'(rem_sh);
  assign quo_nx   = {quo_q[DivW-2:0], div_ge};
  assign div_last = (dcnt_q == DcW'(DivW - 1));

  // Divisors: n (at least 1), and n-1 (at least 1)
  assign n_dvs   = (cnt_nx == '0) ? CntW'(1) : cnt_nx;
  assign var_dvs = (count_q > CntW'(1)) ? CntW'(count_q - CntW'(1)) : CntW'(1);
  assign sum_mag = sum_nx[SumW-1] ? SumW'(-sum_nx) : SumW'(sum_nx);

  // Deviation datapath
  assign dev     = $signed({rdata[SAMPLE_WIDTH-1], rdata})
                 - $signed({mean_q[SAMPLE_WIDTH-1], mean_q});
  assign dev_abs = dev[SAMPLE_WIDTH] ? SAMPLE_WIDTH'(-dev) : SAMPLE_WIDTH'(dev);
  assign prod    = abs_q * abs_q;

  assign pass_done = (rd_cnt_q == count_q) && !v1_q && !v2_q && !v3_q;
  assign fin_go    = !out_valid_q || out_ready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StLoad:    if (in_fire && in_req_i.last_sample) state_d = StDivMean;
      StDivMean: if (div_last) state_d = StPass;
      StPass:    if (pass_done) state_d = StDivAdev;
      StDivAdev: if (div_last) state_d = StDivVar;
      StDivVar:  if (div_last) state_d = StFinish;
      StFinish:  if (fin_go) state_d = StLoad;
      default:   state_d = StLoad;
    endcase
  end

  // Control and set state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StLoad;
      count_q     <= '0;
      sum_q       <= '0;
      min_q       <= {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
      max_q       <= {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
      ovf_q       <= 1'b0;
      rd_cnt_q    <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      dcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      // Response valid: set on a new result, cleared when taken
      if ((state_q == StFinish) && fin_go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        StLoad: begin
          if (in_fire) begin
            if (room) begin
              count_q <= cnt_nx;
              sum_q   <= sum_nx;
              if (x > max_q) max_q <= x;
              if (x < min_q) min_q <= x;
            end else begin
              ovf_q <= 1'b1;
            end
          end
          dcnt_q   <= '0;
          rd_cnt_q <= '0;
        end
        StDivMean, StDivAdev, StDivVar: begin
          dcnt_q <= div_last ? '0 : dcnt_q + DcW'(1);
        end
        StPass: begin
          // Issue one read per cycle, then drain the pipeline
          v1_q <= (rd_cnt_q != count_q);
          if (rd_cnt_q != count_q) rd_cnt_q <= rd_cnt_q + CntW'(1);
          v2_q <= v1_q;
          v3_q <= v2_q;
        end
        StFinish: begin
          if (fin_go) begin
            count_q     <= '0;
            sum_q       <= '0;
            min_q       <= {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
            max_q       <= {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
            ovf_q       <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      StLoad: begin
        // Mean: |sum| / n, sign restored afterwards
        quo_q <= DivW'(sum_mag);
        rem_q <= '0;
        dvs_q <= n_dvs;
        abs_sum_q <= '0;
        sq_sum_q  <= '0;
      end
      StDivMean: begin
        quo_q <= quo_nx;
        rem_q <= rem_nx;
        if (div_last) begin
          mean_q <= sum_q[SumW-1] ? SAMPLE_WIDTH'(-quo_nx) : SAMPLE_WIDTH'(quo_nx);
        end
      end
      StPass: begin
        abs_q <= dev_abs;
        sq_q  <= DivW'(prod >> FRAC_BITS);
        if (v2_q) abs_sum_q <= abs_sum_q + DivW'(abs_q);
        if (v3_q) sq_sum_q  <= sq_sum_q + sq_q;
        if (pass_done) begin
          quo_q <= abs_sum_q;
          rem_q <= '0;
          dvs_q <= n_dvs;
        end
      end
      StDivAdev: begin
        if (div_last) begin
          adev_q <= quo_nx[31:0];
          quo_q  <= sq_sum_q;
          rem_q  <= '0;
          dvs_q  <= var_dvs;
        end else begin
          quo_q <= quo_nx;
          rem_q <= rem_nx;
        end
      end
      StDivVar: begin
        quo_q <= quo_nx;
        rem_q <= rem_nx;
      end
      StFinish: begin
        if (fin_go) begin
          out_q.count         <= 13'(count_q);
          out_q.mean          <= 32'(mean_q);
          out_q.variance      <= (quo_q[DivW-1:sstat_pkg::VarW] != '0) ?
                                 {sstat_pkg::VarW{1'b1}} : quo_q[sstat_pkg::VarW-1:0];
          out_q.total         <= 44'(sum_q);
          out_q.smallest      <= 32'(min_q);
          out_q.largest       <= 32'(max_q);
          out_q.avg_deviation <= adev_q;
          out_q.overflowed    <= ovf_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

### test/sample_set_statistics_tb.sv
// ----------------------------------------------------------------------------
// sample_set_statistics_tb
// Streams sample sets into sample_set_statistics and checks each set's
// statistics against a predictor kept in the bench. Directed sets cover
// value extremes, a single sample and a full store with dropped samples.
// Random sets follow under changing idle patterns on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sample_set_statistics_tb;

  localparam int unsigned Capacity  = 4096;
  localparam int unsigned FracBits  = 16;
  localparam int unsigned CycleLimit = 3000000;
  localparam int unsigned SettleCycles = 400;

  // One queued request plus a hold-off marker for the driver
  typedef struct {
    sstat_pkg::in_req_t req;
    bit      drain;
  } pend_t;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_ready_o;
  sstat_pkg::in_req_t  in_req_i = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  sstat_pkg::out_rsp_t out_rsp_o;

  pend_t    pending_q[$];
  sstat_pkg::out_rsp_t stats_q[$];
  int unsigned total_items;
  int unsigned sent_items;
  int unsigned mismatches;
  int unsigned cycles;

  // Predictor copy of the set
  int          store_m[Capacity];
  int unsigned count_m;
  longint      sum_m;
  int          min_m;
  int          max_m;
  bit          ovf_m;

  sample_set_statistics DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic void clear_set();
    count_m = 0;
    sum_m   = 0;
    min_m   = 32'sh7fffffff;
    max_m   = 32'sh80000000;
    ovf_m   = 1'b0;
  endfunction

  // Take one sample; on a last sample work out the set statistics
  function automatic void take_sample(sstat_pkg::in_req_t r);
    sstat_pkg::out_rsp_t s;
    longint      mean;
    longint      d;
    bit [63:0]   a;
    bit [63:0]   abs_sum;
    bit [63:0]   sq_sum;
    bit [63:0]   var_q;
    bit [63:0]   adev;
    longint      div;
    if (count_m < Capacity) begin
      store_m[count_m] = r.sample;
      count_m++;
      sum_m += longint'(r.sample);
      if (r.sample > max_m) max_m = r.sample;
      if (r.sample < min_m) min_m = r.sample;
    end else begin
      ovf_m = 1'b1;
    end
    if (!r.last_sample) return;
    mean = sum_m / longint'((count_m != 0) ? count_m : 1);
    abs_sum = '0;
    sq_sum = '0;
    for (int unsigned i = 0; i < count_m; i++) begin
      d = longint'(store_m[i]) - mean;
      a = (d < 0) ? 64'(-d) : 64'(d);
      abs_sum += a;
      sq_sum += (a * a) >> FracBits;
    end
    adev = abs_sum / 64'((count_m != 0) ? count_m : 1);
    div = (count_m > 1) ? count_m - 1 : 1;
    var_q = sq_sum / 64'(div);
    if (var_q > 64'hffff_ffff_ffff) var_q = 64'hffff_ffff_ffff;
    s.count         = 13'(count_m);
    s.mean          = 32'(mean);
    s.variance      = var_q[47:0];
    s.total         = 44'(sum_m);
    s.smallest      = min_m;
    s.largest       = max_m;
    s.avg_deviation = adev[31:0];
    s.overflowed    = ovf_m;
    stats_q.push_back(s);
    clear_set();
  endfunction

  task automatic add_sample(input logic [31:0] v, input bit last, input bit drain = 0);
    pend_t p;
    p.req.sample = v;
    p.req.last_sample = last;
    p.drain = drain;
    pending_q.push_back(p);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 4))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 2 * 1048576)) - 1048576);
      2: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      3: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< FracBits;
      default: return $urandom() >> $urandom_range(0, 31);
    endcase
  endfunction

  // Idle odds per hundred cycles: sender then receiver, swapped, then none
  function automatic bit sender_idle();
    if (sent_items < total_items / 3) return $urandom_range(0, 99) < 12;
    if (sent_items < 2 * total_items / 3) return $urandom_range(0, 99) < 61;
    return 1'b0;
  endfunction

  function automatic bit receiver_idle();
    if (sent_items < total_items / 3) return $urandom_range(0, 99) < 61;
    if (sent_items < 2 * total_items / 3) return $urandom_range(0, 99) < 12;
    return 1'b0;
  endfunction

  // Request driver
  always @(posedge clk_i) begin
    bit taken;
    bit nxt_valid;
    taken = in_valid_i && in_ready_o;
    nxt_valid = in_valid_i && !taken;
    if (rst_ni) begin
      if (taken) begin
        take_sample(in_req_i);
        sent_items++;
      end
      if (!nxt_valid && pending_q.size() != 0 && !sender_idle()) begin
        if (!pending_q[0].drain || (stats_q.size() == 0 && !taken)) begin
          in_req_i <= pending_q[0].req;
          pending_q.pop_front();
          nxt_valid = 1'b1;
        end
      end
      in_valid_i <= nxt_valid;
    end
  end

  // Response monitor
  always @(posedge clk_i) begin
    sstat_pkg::out_rsp_t e;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (stats_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected response: %p", out_rsp_o);
        end else begin
          e = stats_q.pop_front();
          if (out_rsp_o.count !== e.count || out_rsp_o.mean !== e.mean ||
              out_rsp_o.variance !== e.variance || out_rsp_o.total !== e.total ||
              out_rsp_o.smallest !== e.smallest || out_rsp_o.largest !== e.largest ||
              out_rsp_o.avg_deviation !== e.avg_deviation ||
              out_rsp_o.overflowed !== e.overflowed) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("stats mismatch");
              $display("  exp %p", e);
              $display("  got %p", out_rsp_o);
            end
          end
        end
      end
      out_ready_i <= !receiver_idle();
    end
  end

  // Run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("sample_set_statistics_tb: errors");
      $finish;
    end
  end

  initial begin
    int unsigned len;
    clear_set();
    // Directed sets: extremes, single samples, mixed signs
    add_sample(32'h7fffffff, 1);
    add_sample(32'h80000000, 1);
    add_sample(32'h00000000, 1);
    add_sample(32'h7fffffff, 0);
    add_sample(32'h80000000, 1);
    add_sample(32'hffffffff, 0);
    add_sample(32'h00000001, 0);
    add_sample(32'h00000000, 1);
    for (int i = 0; i < 4; i++) add_sample(32'h7fffffff, i == 3);
    for (int i = 0; i < 4; i++) add_sample(32'h80000000, i == 3);
    add_sample(32'h00010000, 0);
    add_sample(32'hffff0000, 0);
    add_sample(32'h00030000, 1);
    // Full store, dropped samples and a dropped last sample
    for (int i = 0; i < Capacity; i++) add_sample(pick_value(), 0, i == 0);
    add_sample(32'h7fffffff, 0);
    add_sample(32'h80000000, 0);
    add_sample(32'h12345678, 1);
    // Overflow flag must be cleared for the next set
    add_sample(32'h00020000, 0, 1);
    add_sample(32'h00040000, 1);
    // Random sets, mostly short
    for (int k = 0; k < 1850;) begin
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 300) : $urandom_range(1, 24);
      for (int unsigned j = 0; j < len; j++) add_sample(pick_value(), j == len - 1);
      k += len;
    end
    total_items = pending_q.size();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (pending_q.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
    while (in_valid_i || stats_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("sample_set_statistics_tb: clean");
    end else begin
      $display("sample_set_statistics_tb: errors");
    end
    $finish;
  end

endmodule

### sample_set_statistics.f
design/sstat_pkg.sv
design/sstat_ram.sv
design/sample_set_statistics.sv
test/sample_set_statistics_tb.sv
